@@ rtl/core/nlc_pkg.sv @@
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared types, constants and the CORDIC angle table for the landmark search.
// ----------------------------------------------------------------------------
package nlc_pkg;
	localparam int TableEntries = 64;
	localparam int IdxW         = $clog2(TableEntries);
	localparam int CntW         = IdxW + 1;
	localparam int CordicSteps  = 16;
	localparam int StepW        = $clog2(CordicSteps + 1);
	localparam int ZW           = 26;
	localparam int VW           = 36;
	localparam int D2W          = 35;

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CONE   = 2'd2;
	localparam logic [1:0] FUNC_SPARE  = 2'd3;

	localparam logic CFG_ENTRY_COUNT = 1'b0;
	localparam logic CFG_HALF_ANGLE  = 1'b1;

	localparam logic signed [ZW-1:0] HalfTurnFine = 26'sd11796480;
	localparam logic [15:0] HalfAngleReset = 16'd5867;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EVAL, ST_CORDIC, ST_CMP, ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [15:0] id;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
	} cordic_req_t;

	typedef struct packed {
		logic        done;
		logic signed [17:0] bearing;
	} cordic_rsp_t;

	function automatic logic signed [ZW-1:0] atan_fine(input logic [4:0] i);
		case (i)
			5'd0:  atan_fine = 26'sd2949120;
			5'd1:  atan_fine = 26'sd1740967;
			5'd2:  atan_fine = 26'sd919879;
			5'd3:  atan_fine = 26'sd466945;
			5'd4:  atan_fine = 26'sd234379;
			5'd5:  atan_fine = 26'sd117304;
			5'd6:  atan_fine = 26'sd58666;
			5'd7:  atan_fine = 26'sd29335;
			5'd8:  atan_fine = 26'sd14668;
			5'd9:  atan_fine = 26'sd7334;
			5'd10: atan_fine = 26'sd3667;
			5'd11: atan_fine = 26'sd1833;
			5'd12: atan_fine = 26'sd917;
			5'd13: atan_fine = 26'sd458;
			5'd14: atan_fine = 26'sd229;
			5'd15: atan_fine = 26'sd115;
			5'd16: atan_fine = 26'sd57;
			5'd17: atan_fine = 26'sd29;
			5'd18: atan_fine = 26'sd14;
			5'd19: atan_fine = 26'sd7;
			5'd20: atan_fine = 26'sd4;
			5'd21: atan_fine = 26'sd2;
			5'd22: atan_fine = 26'sd1;
			default: atan_fine = 26'sd0;
		endcase
	endfunction
endpackage

@@ rtl/core/nlc_if.sv @@
// ----------------------------------------------------------------------------
// nlc_if
// Handshake channels: query in, result out, configuration write.
// ----------------------------------------------------------------------------
interface nlc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [5:0]         entry_index;
	logic signed [15:0] key_id;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [16:0] heading;
	modport source (output valid, func, entry_index, key_id, pos_x, pos_y, heading,
		input ready);
	modport sink (input valid, func, entry_index, key_id, pos_x, pos_y, heading,
		output ready);
endinterface

interface nlc_out_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	modport source (output valid, found, out_x, out_y, input ready);
	modport sink (input valid, found, out_x, out_y, output ready);
endinterface

interface nlc_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/nearest_landmark_in_cone_core.sv @@
// ----------------------------------------------------------------------------
// nearest_landmark_in_cone_core
// Landmark table with id lookup and nearest-in-cone search.
// ----------------------------------------------------------------------------
// channel | dir | word
// q       | in  | func, entry_index, key_id, pos_x, pos_y, heading
// r       | out | found, out_x, out_y
// cfg     | in  | index (0 entry_count, 1 sight_half_angle), data
// Write and spare codes: accept, then result. Lookup: read and evaluate per
// entry, stopping at the first match, then result. Cone query: read, start,
// 16 CORDIC steps, done and compare per entry, then result, paced by the
// single iterative CORDIC. One item at a time; the next is taken once the
// result word has left. Reset clears control and registers; the table holds
// garbage until written. A stalled result holds the block in ST_DONE.
module nearest_landmark_in_cone_core
	import nlc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	nlc_in_if.sink    q,
	nlc_out_if.source r,
	nlc_cfg_if.sink   cfg
);
	entry_t mem [TableEntries];
	entry_t rd_q;
	state_t st_q, st_d;

	logic [CntW-1:0]    count_q, limit;
	logic [15:0]        half_q;
	logic [1:0]         func_q;
	logic signed [15:0] key_q, px_q, py_q;
	logic signed [16:0] head_q;
	logic [IdxW-1:0]    idx_q;
	logic               found_q, best_v_q;
	logic signed [15:0] ox_q, oy_q;
	logic [D2W-1:0]     best_q, d2_q;
	logic signed [16:0] dx, dy;
	logic signed [18:0] diff;
	logic [18:0]        adiff;
	logic               last, accept;
	cordic_req_t        creq;
	cordic_rsp_t        crsp;

	nlc_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp));

	assign cfg.ready = 1'b1;
	assign limit = (count_q > CntW'(TableEntries)) ? CntW'(TableEntries) : count_q;
	assign last  = (CntW'(idx_q) + 1'b1) >= limit;
	assign q.ready = (st_q == ST_IDLE);
	assign accept = q.valid && q.ready;
	assign dx = 17'(rd_q.x) - 17'(px_q);
	assign dy = 17'(rd_q.y) - 17'(py_q);
	assign diff  = 19'(head_q) - 19'(crsp.bearing);
	assign adiff = diff[18] ? 19'(-diff) : 19'(diff);
	assign creq.start = (st_q == ST_EVAL) && (func_q == FUNC_CONE);
	assign creq.dx = dx;
	assign creq.dy = dy;

	always_ff @(posedge clk) begin
		if (accept && q.func == FUNC_WRITE)
			mem[q.entry_index] <= '{q.key_id, q.pos_x, q.pos_y};
		rd_q <= mem[idx_q];
		if (creq.start)
			d2_q <= D2W'(34'(dx * dx)) + D2W'(34'(dy * dy));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			half_q <= HalfAngleReset;
			idx_q <= '0;
			found_q <= 1'b0;
			best_v_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			best_q <= '0;
			func_q <= FUNC_WRITE;
			key_q <= '0;
			px_q <= '0;
			py_q <= '0;
			head_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg.valid) begin
				case (cfg.index)
					CFG_ENTRY_COUNT: count_q <= cfg.data[CntW-1:0];
					default: half_q <= cfg.data;
				endcase
			end
			if (accept) begin
				func_q <= q.func;
				key_q <= q.key_id;
				px_q <= q.pos_x;
				py_q <= q.pos_y;
				head_q <= q.heading;
				idx_q <= '0;
				best_v_q <= 1'b0;
				found_q <= 1'b0;
				if (q.func == FUNC_LOOKUP || q.func == FUNC_CONE) begin
					ox_q <= '1;
					oy_q <= '1;
				end else begin
					ox_q <= '0;
					oy_q <= '0;
				end
			end
			if (st_q == ST_EVAL && func_q == FUNC_LOOKUP) begin
				if (rd_q.id == key_q) begin
					found_q <= 1'b1;
					ox_q <= rd_q.x;
					oy_q <= rd_q.y;
				end
				idx_q <= idx_q + 1'b1;
			end
			if (st_q == ST_CMP) begin
				if (adiff <= 19'(half_q) && (!best_v_q || d2_q < best_q)) begin
					best_v_q <= 1'b1;
					found_q <= 1'b1;
					best_q <= d2_q;
					ox_q <= rd_q.x;
					oy_q <= rd_q.y;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (accept) begin
				if ((q.func == FUNC_LOOKUP || q.func == FUNC_CONE) && limit != 0)
					st_d = ST_READ;
				else
					st_d = ST_DONE;
			end
			ST_READ: st_d = ST_EVAL;
			ST_EVAL: begin
				if (func_q == FUNC_CONE)
					st_d = ST_CORDIC;
				else if (rd_q.id == key_q || last)
					st_d = ST_DONE;
				else
					st_d = ST_READ;
			end
			ST_CORDIC: if (crsp.done) st_d = ST_CMP;
			ST_CMP: st_d = last ? ST_DONE : ST_READ;
			ST_DONE: if (r.ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign r.valid = (st_q == ST_DONE);
	assign r.found = found_q;
	assign r.out_x = ox_q;
	assign r.out_y = oy_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q.ready |-> !r.valid) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r.valid && !r.ready |=> r.valid && $stable(r.out_x)) else $error("result dropped");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		r.valid && !r.found && (func_q == FUNC_LOOKUP || func_q == FUNC_CONE)
		|-> r.out_x == -16'sd1)
		else $error("not found must give -1");
endmodule

@@ rtl/core/nlc_cordic.sv @@
// ----------------------------------------------------------------------------
// nlc_cordic
// Iterative vectoring CORDIC, one step per cycle, bearing in 1/256 degree.
// ----------------------------------------------------------------------------
module nlc_cordic
	import nlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);
	logic signed [VW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q, base_q;
	logic [StepW-1:0]     step_q;
	logic                 busy_q, zero_q, done_q;
	logic signed [VW-1:0] xs, ys;
	logic signed [ZW+1:0] sum;

	assign xs  = x_q >>> step_q;
	assign ys  = y_q >>> step_q;
	assign sum = ZW'(base_q) + ZW'(z_q) + (ZW+2)'(128);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == StepW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			zero_q <= (req.dx == 0) && (req.dy == 0);
			z_q    <= '0;
			if (req.dx < 0) begin
				base_q <= (req.dy >= 0) ? HalfTurnFine : -HalfTurnFine;
				x_q    <= VW'(-$signed({req.dx[16], req.dx})) <<< 16;
				y_q    <= VW'(-$signed({req.dy[16], req.dy})) <<< 16;
			end else begin
				base_q <= '0;
				x_q    <= VW'(req.dx) <<< 16;
				y_q    <= VW'(req.dy) <<< 16;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_fine(5'(step_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_fine(5'(step_q));
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.bearing = zero_q ? '0 : 18'(sum >>> 8);
endmodule

@@ tb/sv/nearest_landmark_in_cone_core_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_landmark_in_cone_core_tb
// Drives writes, id lookups and cone queries through the handshake channels,
// predicts each result word with a fixed-point CORDIC bearing model and
// checks the returned words in order under several idling phases.
// ----------------------------------------------------------------------------
module nearest_landmark_in_cone_core_tb
	import nlc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]         func;
		logic [5:0]         entry_index;
		logic signed [15:0] key_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [16:0] heading;
	} query_t;

	typedef struct {
		logic               found;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nlc_in_if  q();
	nlc_out_if r();
	nlc_cfg_if cfg();

	nearest_landmark_in_cone_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.q      (q.sink),
		.r      (r.source),
		.cfg    (cfg.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	query_t  query_fifo[$];
	answer_t answer_fifo[$];

	logic signed [15:0] tbl_id[TableEntries];
	logic signed [15:0] tbl_x[TableEntries];
	logic signed [15:0] tbl_y[TableEntries];
	int unsigned        live_entries = 0;
	int unsigned        half_angle = HalfAngleReset;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  errors = 0;
	int  stall_cycles = 0;
	bit  hold_send = 1'b0;

	function automatic void queue_query(query_t it);
		query_fifo.insert(query_fifo.size(), it);
	endfunction

	function automatic longint cordic_bearing(longint dx, longint dy);
		longint x, y, z, base, xs, ys;
		z = 0;
		base = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (dx < 0) begin
			base = (dy >= 0) ? 11796480 : -11796480;
			dx = -dx;
			dy = -dy;
		end
		x = dx * 65536;
		y = dy * 65536;
		for (int i = 0; i < CordicSteps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_fine(5'(i));
			end else begin
				x -= ys; y += xs; z -= atan_fine(5'(i));
			end
		end
		return (base + z + 128) >>> 8;
	endfunction

	function automatic answer_t predict_answer(query_t it);
		answer_t a;
		longint dx, dy, diff, d2, best_d2;
		a.found = 1'b0;
		a.out_x = 16'sd0;
		a.out_y = 16'sd0;
		best_d2 = 0;
		case (it.func)
			FUNC_WRITE: begin
				tbl_id[it.entry_index] = it.key_id;
				tbl_x[it.entry_index] = it.pos_x;
				tbl_y[it.entry_index] = it.pos_y;
			end
			FUNC_LOOKUP: begin
				a.out_x = -16'sd1;
				a.out_y = -16'sd1;
				for (int i = 0; i < live_entries; i++)
					if (!a.found && tbl_id[i] == it.key_id) begin
						a.found = 1'b1;
						a.out_x = tbl_x[i];
						a.out_y = tbl_y[i];
					end
			end
			FUNC_CONE: begin
				a.out_x = -16'sd1;
				a.out_y = -16'sd1;
				for (int i = 0; i < live_entries; i++) begin
					dx = longint'(tbl_x[i]) - longint'(it.pos_x);
					dy = longint'(tbl_y[i]) - longint'(it.pos_y);
					diff = longint'(it.heading) - cordic_bearing(dx, dy);
					if (diff < 0)
						diff = -diff;
					d2 = dx * dx + dy * dy;
					if (diff <= half_angle && (!a.found || d2 < best_d2)) begin
						a.found = 1'b1;
						best_d2 = d2;
						a.out_x = tbl_x[i];
						a.out_y = tbl_y[i];
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid       <= 1'b0;
			q.func        <= FUNC_WRITE;
			q.entry_index <= '0;
			q.key_id      <= '0;
			q.pos_x       <= '0;
			q.pos_y       <= '0;
			q.heading     <= '0;
		end else if (!q.valid || q.ready) begin
			if (query_fifo.size() > 0 && !hold_send
				&& $urandom_range(99) >= send_idle_pct) begin
				query_t it;
				it = query_fifo.pop_front();
				answer_fifo.insert(answer_fifo.size(), predict_answer(it));
				q.valid       <= 1'b1;
				q.func        <= it.func;
				q.entry_index <= it.entry_index;
				q.key_id      <= it.key_id;
				q.pos_x       <= it.pos_x;
				q.pos_y       <= it.pos_y;
				q.heading     <= it.heading;
			end else begin
				q.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r.ready <= 1'b0;
		end else begin
			r.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((q.valid && q.ready) || (r.valid && r.ready) || (cfg.valid && cfg.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (r.valid && r.ready) begin
				if (answer_fifo.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: found=%0d x=%0d y=%0d",
							r.found, r.out_x, r.out_y);
				end else begin
					answer_t e;
					e = answer_fifo.pop_front();
					if (r.found !== e.found || r.out_x !== e.out_x || r.out_y !== e.out_y)
						begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
								e.found, e.out_x, e.out_y, r.found, r.out_x, r.out_y);
					end
				end
			end
			if (stall_cycles > 20000) begin
				$display("nearest_landmark_in_cone_core_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (query_fifo.size() > 0 || answer_fifo.size() > 0 || q.valid)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_ENTRY_COUNT)
			live_entries = (data[6:0] > TableEntries) ? TableEntries : data[6:0];
		else
			half_angle = data;
		@(posedge clk);
	endtask

	function automatic query_t make_query(logic [1:0] f, logic [5:0] slot,
		logic signed [15:0] id, logic signed [15:0] x, logic signed [15:0] y,
		logic signed [16:0] hd);
		query_t it;
		it.func = f; it.entry_index = slot; it.key_id = id;
		it.pos_x = x; it.pos_y = y; it.heading = hd;
		return it;
	endfunction

	function automatic logic signed [15:0] rand_coord(bit narrow);
		if (narrow)
			return 16'($signed($urandom_range(400)) - 200);
		return 16'($urandom);
	endfunction

	function automatic logic signed [16:0] rand_heading();
		case ($urandom_range(3))
			0: return 17'($urandom);
			default: return 17'($signed($urandom_range(92160)) - 46080);
		endcase
	endfunction

	task automatic fill_table(int n, bit narrow);
		for (int i = 0; i < n; i++)
			queue_query(make_query(FUNC_WRITE, 6'(i), 16'($urandom_range(15)),
				rand_coord(narrow), rand_coord(narrow), 17'd0));
	endtask

	task automatic random_batch(int n, bit narrow);
		int c;
		for (int k = 0; k < n; k++) begin
			c = $urandom_range(99);
			if (c < 10)
				queue_query(make_query(FUNC_WRITE, 6'($urandom_range(live_entries
					> 0 ? live_entries - 1 : 0)), 16'($urandom_range(15)),
					rand_coord(narrow), rand_coord(narrow), rand_heading()));
			else if (c < 14)
				queue_query(make_query(FUNC_WRITE, 6'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 17'($urandom)));
			else if (c < 40)
				queue_query(make_query(FUNC_LOOKUP, 6'($urandom),
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(17)),
					16'($urandom), 16'($urandom), 17'($urandom)));
			else if (c < 97)
				queue_query(make_query(FUNC_CONE, 6'($urandom), 16'($urandom),
					rand_coord(narrow), rand_coord(narrow), rand_heading()));
			else
				queue_query(make_query(FUNC_SPARE, 6'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 17'($urandom)));
		end
	endtask

	initial begin
		int idle_mode[4][2];
		int counts[4];
		int halves[4];
		idle_mode = '{'{0, 0}, '{69, 0}, '{0, 69}, '{32, 32}};
		counts = '{64, 8, 1, 100};
		halves = '{46080, 0, 65535, 1500};
		cfg.valid = 1'b0; cfg.index = CFG_ENTRY_COUNT; cfg.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, tie on slot order, zero offset
		queue_query(make_query(FUNC_LOOKUP, 0, 0, 0, 0, 0));
		queue_query(make_query(FUNC_CONE, 0, 0, 0, 0, 0));
		queue_query(make_query(FUNC_WRITE, 0, -16'sd32768, -16'sd32768,
			-16'sd32768, 17'sd46080));
		queue_query(make_query(FUNC_WRITE, 1, 16'sd32767, 16'sd32767,
			16'sd32767, -17'sd46080));
		queue_query(make_query(FUNC_WRITE, 2, 16'sd5, 16'sd10, 16'sd0, 0));
		queue_query(make_query(FUNC_WRITE, 3, 16'sd5, 16'sd0, 16'sd10, 0));
		queue_query(make_query(FUNC_WRITE, 4, 16'sd7, -16'sd10, 16'sd0, 0));
		queue_query(make_query(FUNC_WRITE, 5, 16'sd7, -16'sd10, -16'sd1, 0));
		queue_query(make_query(FUNC_WRITE, 63, 16'sd9, 16'sd3, 16'sd3, 0));
		queue_query(make_query(FUNC_SPARE, 6'h3f, -1, -1, -1, -1));
		wait_drained();
		write_reg(CFG_ENTRY_COUNT, 16'd6);
		write_reg(CFG_HALF_ANGLE, 16'd46080);
		queue_query(make_query(FUNC_LOOKUP, 0, 16'sd5, 0, 0, 0));
		queue_query(make_query(FUNC_LOOKUP, 0, -16'sd32768, 0, 0, 0));
		queue_query(make_query(FUNC_LOOKUP, 0, 16'sd32767, 0, 0, 0));
		queue_query(make_query(FUNC_LOOKUP, 0, 16'sd9, 0, 0, 0));
		queue_query(make_query(FUNC_CONE, 0, 0, 16'sd0, 16'sd0, 17'sd0));
		queue_query(make_query(FUNC_CONE, 0, 0, 16'sd10, 16'sd0, 17'sd0));
		queue_query(make_query(FUNC_CONE, 0, 0, -16'sd32768, 16'sd32767,
			-17'sd46080));
		queue_query(make_query(FUNC_CONE, 0, 0, 16'sd32767, -16'sd32768,
			17'sd46080));
		queue_query(make_query(FUNC_CONE, 0, 0, 16'sd0, 16'sd0, 17'sd65535));
		wait_drained();
		write_reg(CFG_HALF_ANGLE, 16'd0);
		queue_query(make_query(FUNC_CONE, 0, 0, 16'sd0, 16'sd0, 17'sd0));
		queue_query(make_query(FUNC_CONE, 0, 0, 16'sd0, 16'sd0, 17'sd23040));
		wait_drained();
		write_reg(CFG_HALF_ANGLE, 16'd5867);
		fill_table(64, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_mode[ph][0];
			recv_stall_pct = idle_mode[ph][1];
			write_reg(CFG_ENTRY_COUNT, 16'(counts[ph]));
			write_reg(CFG_HALF_ANGLE, 16'(halves[ph]));
			if (ph == 1)
				fill_table(8, 1'b0);
			random_batch(ph == 0 ? 150 : 430, ph != 1);
			if (ph == 3) begin
				hold_send = 1'b1;
				while (answer_fifo.size() > 0 || q.valid)
					@(posedge clk);
				hold_send = 1'b0;
			end
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(CFG_ENTRY_COUNT, 16'd0);
		random_batch(10, 1'b1);
		wait_drained();
		repeat (100) @(posedge clk);

		if (errors == 0)
			$display("nearest_landmark_in_cone_core_tb: done, clean");
		else
			$display("nearest_landmark_in_cone_core_tb: done, errors");
		$finish;
	end
endmodule
